>>> hdl/fstm_pkg.sv
// Package for the flat span texture mapper: shared constants, command codes and
// the packed transaction types used on the ports and between front, queue and back.
// No dependencies.
package fstm_pkg;

    // Screen and texture geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int LIGHT_LEVELS  = 64;
    localparam int MAX_RUN       = 64;
    localparam int TEX_DIM_BITS  = 6;       // 64x64 flat
    localparam int TEXEL_DEPTH   = 4096;
    localparam int CMAP_DEPTH    = 16384;
    localparam int QUEUE_DEPTH   = 4;

    localparam int TEX_ADDR_W  = 12;
    localparam int CMAP_ADDR_W = 14;
    localparam int SROW_W      = 9;         // view row plus window offset
    localparam int SCOL_W      = 11;        // view column plus offset plus run
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // Input op codes
    localparam logic [1:0] OP_LOAD_TEXEL = 2'd0;
    localparam logic [1:0] OP_LOAD_CMAP  = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;

    // Configuration register indexes
    localparam logic REG_WINDOW_X = 1'b0;
    localparam logic REG_WINDOW_Y = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [13:0]        load_addr;
        logic [7:0]         load_data;
        logic [8:0]         start_x;
        logic [5:0]         run_length;
        logic [7:0]         row;
        logic [5:0]         light_level;
        logic signed [31:0] u_start;
        logic signed [31:0] v_start;
        logic signed [31:0] u_step;
        logic signed [31:0] v_step;
    } item_t;

    typedef struct packed {
        logic [15:0] fb_addr;
        logic [7:0]  colour;
        logic        out_of_range;
        logic        last;
    } pixel_t;

    typedef enum logic [1:0] {
        CMD_LOAD_TEXEL = 2'd0,
        CMD_LOAD_CMAP  = 2'd1,
        CMD_SPAN       = 2'd2
    } cmd_kind_t;

    // Classified command held in the queue between front and back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [13:0]        load_addr;
        logic [7:0]         load_data;
        logic [15:0]        row_base;   // screen row times width, 0 when row is off screen
        logic               row_bad;
        logic [SCOL_W-1:0]  scol0;
        logic [5:0]         last_idx;
        logic [5:0]         light;
        logic [31:0]        u;
        logic [31:0]        v;
        logic [31:0]        du;
        logic [31:0]        dv;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic valid;
    } q_rd_t;

endpackage

>>> hdl/fstm_front.sv
// Front end of the flat span texture mapper: window registers, input accept and
// classification of each item into a queue command. Depends on fstm_pkg.
module fstm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fstm_pkg::item_t      item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 q_full,
    output logic                 accept,
    output logic                 push,
    output fstm_pkg::cmd_t       cmd
);

    logic [8:0] window_x_reg;
    logic [7:0] window_y_reg;

    logic [fstm_pkg::SROW_W-1:0] srow;
    logic [17:0]                 row_prod;
    logic [5:0]                  light_sat;
    logic [5:0]                  last_idx;
    logic                        keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_x_reg <= '0;
            window_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fstm_pkg::REG_WINDOW_X: window_x_reg <= cfg_data;
                fstm_pkg::REG_WINDOW_Y: window_y_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign accept = start && !q_full;

    always_comb
    begin
        srow     = fstm_pkg::SROW_W'(item.row) + fstm_pkg::SROW_W'(window_y_reg);
        row_prod = 18'(srow) * 18'(fstm_pkg::SCREEN_WIDTH);

        light_sat = item.light_level;
        if (32'(item.light_level) > fstm_pkg::LIGHT_LEVELS - 1)
            light_sat = 6'(fstm_pkg::LIGHT_LEVELS - 1);

        last_idx = item.run_length;
        if (32'(item.run_length) > fstm_pkg::MAX_RUN - 1)
            last_idx = 6'(fstm_pkg::MAX_RUN - 1);

        cmd           = '0;
        cmd.load_addr = item.load_addr;
        cmd.load_data = item.load_data;
        cmd.row_bad   = 32'(srow) >= fstm_pkg::SCREEN_HEIGHT;
        cmd.row_base  = cmd.row_bad ? 16'd0 : row_prod[15:0];
        cmd.scol0     = fstm_pkg::SCOL_W'(item.start_x) + fstm_pkg::SCOL_W'(window_x_reg);
        cmd.last_idx  = last_idx;
        cmd.light     = light_sat;
        cmd.u         = item.u_start;
        cmd.v         = item.v_start;
        cmd.du        = item.u_step;
        cmd.dv        = item.v_step;

        keep     = 1'b0;
        cmd.kind = fstm_pkg::CMD_SPAN;
        unique case (item.op)
            fstm_pkg::OP_LOAD_TEXEL:
            begin
                cmd.kind = fstm_pkg::CMD_LOAD_TEXEL;
                // drop texel writes beyond the flat
                keep = (item.load_addr[13:12] == 2'b00);
            end
            fstm_pkg::OP_LOAD_CMAP:
            begin
                cmd.kind = fstm_pkg::CMD_LOAD_CMAP;
                keep     = 1'b1;
            end
            fstm_pkg::OP_DRAW:
            begin
                cmd.kind = fstm_pkg::CMD_SPAN;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = accept && keep;

endmodule

>>> hdl/fstm_queue.sv
// Short command queue between the front end and the span engine.
// Depends on fstm_pkg.
module fstm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fstm_pkg::cmd_t       wr_cmd,
    output fstm_pkg::q_wr_t      wr,
    input  logic                 push,
    input  logic                 pop,
    output fstm_pkg::q_rd_t      rd,
    output fstm_pkg::cmd_t       rd_cmd
);

    fstm_pkg::cmd_t                entry_reg [fstm_pkg::QUEUE_DEPTH];
    logic [fstm_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [fstm_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [fstm_pkg::Q_CNT_W-1:0] count_reg;
    logic [fstm_pkg::Q_CNT_W-1:0] count_next;

    assign wr.push  = push;
    assign wr.full  = (count_reg == fstm_pkg::Q_CNT_W'(fstm_pkg::QUEUE_DEPTH));
    assign rd.pop   = pop;
    assign rd.valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && wr.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !rd.valid))
        else $error("queue pop while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

>>> hdl/fstm_back.sv
// Span engine of the flat span texture mapper: texel and colormap stores, span
// sequencer and the two-read pixel pipeline. Depends on fstm_pkg.
module fstm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fstm_pkg::q_rd_t      q,
    input  fstm_pkg::cmd_t       cmd,
    output logic                 pop,
    output logic                 pixel_valid,
    output fstm_pkg::pixel_t     pixel
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SPAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] texel_mem [fstm_pkg::TEXEL_DEPTH];
    logic [7:0] cmap_mem  [fstm_pkg::CMAP_DEPTH];

    // span registers
    logic [31:0]                 u_reg, v_reg, du_reg, dv_reg;
    logic [fstm_pkg::SCOL_W-1:0] scol_reg;
    logic [15:0]                 base_reg;
    logic                        row_bad_reg;
    logic [5:0]                  idx_reg;
    logic [5:0]                  last_idx_reg;
    logic [5:0]                  light_reg;

    // pixel pipeline
    logic        p1_valid_reg, p2_valid_reg;
    logic [15:0] p1_fa_reg, p2_fa_reg;
    logic        p1_bad_reg, p2_bad_reg;
    logic        p1_last_reg, p2_last_reg;
    logic [5:0]  p1_light_reg;
    logic [7:0]  texel_rd_reg;
    logic [7:0]  cmap_rd_reg;

    logic                              emit;
    logic                              span_done;
    logic                              tex_we, cmap_we;
    logic [fstm_pkg::TEX_ADDR_W-1:0]   spot;
    logic                              bad;
    logic [15:0]                       fa;

    assign emit      = (state_reg == S_SPAN);
    assign span_done = emit && (idx_reg == last_idx_reg);
    assign pop       = (state_reg == S_IDLE) && q.valid;
    assign tex_we    = pop && (cmd.kind == fstm_pkg::CMD_LOAD_TEXEL);
    assign cmap_we   = pop && (cmd.kind == fstm_pkg::CMD_LOAD_CMAP);

    always_comb
    begin
        // v bits 16..21 pick the flat row, u bits 16..21 the column
        spot = {v_reg[16 +: fstm_pkg::TEX_DIM_BITS], u_reg[16 +: fstm_pkg::TEX_DIM_BITS]};
        bad  = row_bad_reg || (32'(scol_reg) >= fstm_pkg::SCREEN_WIDTH);
        fa   = bad ? 16'd0 : (base_reg + 16'(scol_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (pop && cmd.kind == fstm_pkg::CMD_SPAN)
                    state_next = S_SPAN;
            S_SPAN:
                if (span_done)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tex_we)
            texel_mem[cmd.load_addr[fstm_pkg::TEX_ADDR_W-1:0]] <= cmd.load_data;
        texel_rd_reg <= texel_mem[spot];
    end

    always_ff @(posedge clk)
    begin
        if (cmap_we)
            cmap_mem[cmd.load_addr] <= cmd.load_data;
        cmap_rd_reg <= cmap_mem[{p1_light_reg, texel_rd_reg}];
    end

    // Span payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            u_reg        <= cmd.u;
            v_reg        <= cmd.v;
            du_reg       <= cmd.du;
            dv_reg       <= cmd.dv;
            scol_reg     <= cmd.scol0;
            base_reg     <= cmd.row_base;
            row_bad_reg  <= cmd.row_bad;
            last_idx_reg <= cmd.last_idx;
            light_reg    <= cmd.light;
            idx_reg      <= '0;
        end
        else if (emit)
        begin
            u_reg    <= u_reg + du_reg;
            v_reg    <= v_reg + dv_reg;
            scol_reg <= scol_reg + 1'b1;
            idx_reg  <= idx_reg + 1'b1;
        end

        p1_fa_reg    <= fa;
        p1_bad_reg   <= bad;
        p1_last_reg  <= span_done;
        p1_light_reg <= light_reg;
        p2_fa_reg    <= p1_fa_reg;
        p2_bad_reg   <= p1_bad_reg;
        p2_last_reg  <= p1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= emit;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    assign pixel_valid        = p2_valid_reg;
    assign pixel.fb_addr      = p2_fa_reg;
    assign pixel.colour       = cmap_rd_reg;
    assign pixel.out_of_range = p2_bad_reg;
    assign pixel.last         = p2_last_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q.pop |-> (state_reg == S_IDLE))
        else $error("command taken while a span is running");

    a_off_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.out_of_range) |-> (pixel.fb_addr == 16'd0))
        else $error("off-screen pixel carries an address");

    a_last_ends_span: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.last) |-> ($past(state_reg, 2) == S_SPAN
            && $past(state_reg, 1) == S_IDLE))
        else $error("last pixel does not close the span");

    a_span_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPAN) |-> ##2 pixel_valid)
        else $error("span cycle produced no pixel");

endmodule

>>> hdl/flat_span_texture_mapper.sv
// Top level of the flat span texture mapper: front end, command queue and span engine.
// Depends on fstm_pkg, fstm_front, fstm_queue and fstm_back.
//
// Transactions enter on start while busy is low; busy rises only when the
// four-entry command queue is full. Texel and colormap loads and draw spans are
// carried out strictly in order. A load is executed in the span engine as it is
// taken from the queue; a span is first fetched from the queue, then walked
// one pixel per cycle, set by the single read port of each store. Each pixel shows
// on pixel with pixel_valid high for exactly one cycle, after its texel read and
// then its colormap read, each registered. The receiver cannot stall the block,
// so it must take every pixel in the cycle it appears. The stores power up with
// unknown contents and need no clearing pass; draw only from entries already
// loaded. Write window_x and window_y only while no span is pending or in flight.
module flat_span_texture_mapper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fstm_pkg::item_t      item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    output logic                 pixel_valid,
    output fstm_pkg::pixel_t     pixel
);

    fstm_pkg::cmd_t  front_cmd;
    fstm_pkg::cmd_t  head_cmd;
    fstm_pkg::q_wr_t q_wr;
    fstm_pkg::q_rd_t q_rd;
    logic            accept;
    logic            push;
    logic            pop;

    // Classify and hand commands to the queue; op 3 and out-of-flat texel writes drop here
    fstm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_wr.full),
        .accept    (accept),
        .push      (push),
        .cmd       (front_cmd)
    );

    fstm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cmd (front_cmd),
        .wr     (q_wr),
        .push   (push),
        .pop    (pop),
        .rd     (q_rd),
        .rd_cmd (head_cmd)
    );

    // Execute loads and walk spans one pixel per cycle
    fstm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q           (q_rd),
        .cmd         (head_cmd),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel       (pixel)
    );

    // Hold off new transactions while the queue has no room
    assign busy = q_wr.full;

    a_accept_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !q_wr.full)
        else $error("transaction accepted with a full queue");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> accept)
        else $error("queue written without an accepted transaction");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !pop) |=> busy)
        else $error("busy dropped without a queue pop");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for flat_span_texture_mapper: directed and random load and span
// transactions, a per-pixel predictor and in-order checking of every pixel strobe.
// Depends on fstm_pkg and the flat_span_texture_mapper RTL.
module tb_top;

    // Op code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Quiet cycles before a window write: covers loads still draining from the queue
    localparam int SETTLE_CYCLES  = 16;
    // Cycles to hold at the end: one full span plus the read pipeline
    localparam int TAIL_CYCLES    = 80;
    // Cycles without any transaction or pixel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Transactions per random phase, fill loads included
    localparam int PHASE_ITEMS    = 40;

    typedef enum logic [1:0] {
        JOB_SEND,   // present a transaction on start/item
        JOB_REG,    // write one window register once the block is idle
        JOB_DRAIN   // hold the sender until every pixel has come back
    } job_kind_t;

    typedef struct {
        job_kind_t         kind;
        fstm_pkg::item_t   txn;
        logic              idx;
        logic [8:0]        value;
        bit                calm;   // no idle burst after this transaction
    } job_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    fstm_pkg::item_t  item = '0;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [8:0]       cfg_data = '0;
    logic             pixel_valid;
    fstm_pkg::pixel_t pixel;

    flat_span_texture_mapper uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel       (pixel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus plan: every job the driver will work through, in order
    // ------------------------------------------------------------------
    job_t pending_jobs[$];

    // Shadow of what the stores will hold once the planned loads land. Used only
    // to make sure no span ever reads an entry that was never written.
    bit         tex_loaded   [fstm_pkg::TEXEL_DEPTH];
    logic [7:0] tex_plan     [fstm_pkg::TEXEL_DEPTH];
    bit         shade_loaded [fstm_pkg::CMAP_DEPTH];

    // ------------------------------------------------------------------
    // Predictor state: own copy of both stores and the window registers
    // ------------------------------------------------------------------
    logic [7:0]       texels [fstm_pkg::TEXEL_DEPTH];
    logic [7:0]       shades [fstm_pkg::CMAP_DEPTH];
    logic [8:0]       win_x = '0;
    logic [7:0]       win_y = '0;
    fstm_pkg::pixel_t expected_pixels[$];

    // Registered views of the scoreboard for the driver, so that it never
    // races the monitor within a time step
    int outstanding = 0;
    int settle = 0;

    int errors = 0;
    int gap_left = 0;
    int quiet_cycles = 0;
    int sent_count = 0;
    int spans_seen = 0;
    int pixels_checked = 0;
    int window_count = 0;

    // ------------------------------------------------------------------
    // Predictor: walk the span one pixel at a time, exactly as the engine does
    // ------------------------------------------------------------------
    function automatic void render_span(fstm_pkg::item_t span);
        logic [31:0]      u;
        logic [31:0]      v;
        logic [7:0]       tex;
        int               count;
        int               light;
        int               srow;
        int               scol;
        bit               off;
        fstm_pkg::pixel_t px;
        u     = span.u_start;
        v     = span.v_start;
        count = int'(span.run_length) + 1;
        light = int'(span.light_level);
        if (count > fstm_pkg::MAX_RUN)
            count = fstm_pkg::MAX_RUN;
        if (light >= fstm_pkg::LIGHT_LEVELS)
            light = fstm_pkg::LIGHT_LEVELS - 1;
        srow = int'(span.row) + int'(win_y);
        for (int i = 0; i < count; i++)
        begin
            // v integer bits pick the texel row, u integer bits the column
            tex  = texels[{v[21:16], u[21:16]}];
            scol = int'(span.start_x) + int'(win_x) + i;
            off  = (srow >= fstm_pkg::SCREEN_HEIGHT) || (scol >= fstm_pkg::SCREEN_WIDTH);
            px.fb_addr      = off ? 16'd0 : 16'(srow * fstm_pkg::SCREEN_WIDTH + scol);
            px.colour       = shades[{6'(light), tex}];
            px.out_of_range = off;
            px.last         = (i == count - 1);
            expected_pixels.push_back(px);
            // coordinates wrap modulo 2^32
            u = u + span.u_step;
            v = v + span.v_step;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic fstm_pkg::item_t random_item();
        fstm_pkg::item_t t;
        t.op          = fstm_pkg::OP_DRAW;
        t.load_addr   = 14'($urandom_range(0, 16383));
        t.load_data   = 8'($urandom_range(0, 255));
        t.start_x     = 9'($urandom_range(0, fstm_pkg::SCREEN_WIDTH - 1));
        t.run_length  = 6'($urandom_range(0, 63));
        t.row         = 8'($urandom_range(0, fstm_pkg::SCREEN_HEIGHT - 1));
        t.light_level = 6'($urandom_range(0, 63));
        t.u_start     = $urandom();
        t.v_start     = $urandom();
        t.u_step      = $urandom();
        t.v_step      = $urandom();
        return t;
    endfunction

    // Mix of wild, near-unit and zero steps; small steps keep re-reading texels
    function automatic logic [31:0] random_step();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0000_FFFF));
            2: return 32'h0;
            default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    // Append a transaction and track which store entries it will fill
    function automatic void queue_item(fstm_pkg::item_t t, bit calm);
        job_t j;
        j.kind  = JOB_SEND;
        j.txn   = t;
        j.idx   = 1'b0;
        j.value = '0;
        j.calm  = calm;
        pending_jobs.push_back(j);
        if (t.op == fstm_pkg::OP_LOAD_TEXEL && t.load_addr < fstm_pkg::TEXEL_DEPTH)
        begin
            tex_loaded[t.load_addr[11:0]] = 1'b1;
            tex_plan[t.load_addr[11:0]]   = t.load_data;
        end
        else if (t.op == fstm_pkg::OP_LOAD_CMAP)
            shade_loaded[t.load_addr] = 1'b1;
    endfunction

    // Queue a span, preceded by loads for every texel and colormap entry it
    // touches that has not been written yet
    function automatic void queue_span(fstm_pkg::item_t span, bit calm);
        logic [31:0]     u;
        logic [31:0]     v;
        logic [11:0]     spot;
        logic [13:0]     shade_idx;
        fstm_pkg::item_t fill;
        u = span.u_start;
        v = span.v_start;
        for (int i = 0; i <= int'(span.run_length); i++)
        begin
            spot = {v[21:16], u[21:16]};
            if (!tex_loaded[spot])
            begin
                fill           = random_item();
                fill.op        = fstm_pkg::OP_LOAD_TEXEL;
                fill.load_addr = {2'b00, spot};
                queue_item(fill, calm);
            end
            shade_idx = {span.light_level, tex_plan[spot]};
            if (!shade_loaded[shade_idx])
            begin
                fill           = random_item();
                fill.op        = fstm_pkg::OP_LOAD_CMAP;
                fill.load_addr = shade_idx;
                queue_item(fill, calm);
            end
            u = u + span.u_step;
            v = v + span.v_step;
        end
        span.op = fstm_pkg::OP_DRAW;
        queue_item(span, calm);
    endfunction

    // Window writes; bit 8 of the row write is junk the block must drop
    function automatic void queue_window(logic [8:0] x, logic [7:0] y);
        job_t j;
        j.kind  = JOB_REG;
        j.txn   = '0;
        j.calm  = 1'b0;
        j.idx   = fstm_pkg::REG_WINDOW_X;
        j.value = x;
        pending_jobs.push_back(j);
        j.idx   = fstm_pkg::REG_WINDOW_Y;
        j.value = {1'($urandom_range(0, 1)), y};
        pending_jobs.push_back(j);
        window_count++;
    endfunction

    function automatic void queue_drain();
        job_t j;
        j.kind  = JOB_DRAIN;
        j.txn   = '0;
        j.idx   = 1'b0;
        j.value = '0;
        j.calm  = 1'b0;
        pending_jobs.push_back(j);
    endfunction

    // One random phase: mostly well-formed spans (with their fill loads),
    // plus stray loads, ignored op codes and occasional drains
    function automatic void random_phase(bit steady);
        fstm_pkg::item_t t;
        int              done;
        int              pick;
        int              jobs_prior;
        bit              calm;
        logic [5:0]      levels [4];
        done = 0;
        calm = steady;
        // favor a few light levels so colormap fills get reused
        foreach (levels[k])
            levels[k] = 6'($urandom_range(0, 63));
        while (done < PHASE_ITEMS)
        begin
            t    = random_item();
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 1) != 0)
                    t.run_length = 6'($urandom_range(0, 7));
                if ($urandom_range(0, 3) != 0)
                    t.light_level = levels[$urandom_range(0, 3)];
                t.u_step = random_step();
                t.v_step = random_step();
                jobs_prior = pending_jobs.size();
                queue_span(t, calm);
                done += pending_jobs.size() - jobs_prior;
            end
            else if (pick < 75)
            begin
                t.op = fstm_pkg::OP_LOAD_TEXEL;
                // keep most texel writes inside the store, some above it
                if ($urandom_range(0, 3) != 0)
                    t.load_addr = 14'($urandom_range(0, fstm_pkg::TEXEL_DEPTH - 1));
                queue_item(t, calm);
                done++;
            end
            else if (pick < 90)
            begin
                t.op = fstm_pkg::OP_LOAD_CMAP;
                queue_item(t, calm);
                done++;
            end
            else if (pick < 94)
            begin
                t.op = OP_UNUSED;
                queue_item(t, calm);
                done++;
            end
            else if (pick < 96 && !steady)
                queue_drain();
            else if (!steady)
                calm = !calm;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued transactions on start/item, insert idle bursts,
    // and hold window writes until the block has gone quiet
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic start_n;
        logic we_n;
        job_t head;
        start_n = 1'b0;
        we_n    = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                // transaction taken at this edge: drop it and maybe go idle
                if (!pending_jobs[0].calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 14);
                pending_jobs.delete(0);
                sent_count++;
            end
            if (start && busy)
                start_n = 1'b1;     // hold the transaction until busy drops
            else if (gap_left != 0)
                gap_left--;
            else if (pending_jobs.size() != 0)
            begin
                head = pending_jobs[0];
                case (head.kind)
                    JOB_SEND:
                    begin
                        start_n = 1'b1;
                        item   <= head.txn;
                    end
                    JOB_REG:
                    begin
                        // only with nothing on the bus, nothing expected and
                        // loads given time to drain out of the queue
                        if (!start && outstanding == 0 && settle >= SETTLE_CYCLES)
                        begin
                            we_n       = 1'b1;
                            cfg_index <= head.idx;
                            cfg_data  <= head.value;
                            pending_jobs.delete(0);
                        end
                    end
                    default:
                    begin
                        if (!start && outstanding == 0)
                            pending_jobs.delete(0);
                    end
                endcase
            end
        end
        start  <= start_n;
        cfg_we <= we_n;
    end

    // ------------------------------------------------------------------
    // Monitor: check each pixel strobe against the oldest expectation, then
    // feed accepted transactions and register writes into the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fstm_pkg::pixel_t want;
        if (rst_n)
        begin
            if (pixel_valid)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with nothing expected: fb_addr %0d colour %0d",
                           pixel.fb_addr, pixel.colour);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("fb_addr", want.fb_addr, pixel.fb_addr);
                    check_field("colour", want.colour, pixel.colour);
                    check_field("out_of_range", want.out_of_range, pixel.out_of_range);
                    check_field("last", want.last, pixel.last);
                end
                pixels_checked++;
            end
            if (start && !busy)
            begin
                case (item.op)
                    fstm_pkg::OP_LOAD_TEXEL:
                    begin
                        // writes above the texel store are dropped
                        if (item.load_addr < fstm_pkg::TEXEL_DEPTH)
                            texels[item.load_addr[11:0]] = item.load_data;
                    end
                    fstm_pkg::OP_LOAD_CMAP:
                        shades[item.load_addr] = item.load_data;
                    fstm_pkg::OP_DRAW:
                    begin
                        render_span(item);
                        spans_seen++;
                    end
                    default: ;
                endcase
            end
            if (cfg_we)
            begin
                if (cfg_index == fstm_pkg::REG_WINDOW_X)
                    win_x = cfg_data;
                else
                    win_y = cfg_data[7:0];
            end
            outstanding <= expected_pixels.size();
            if (pixel_valid || (start && !busy) || expected_pixels.size() != 0)
                settle <= 0;
            else if (settle < SETTLE_CYCLES)
                settle <= settle + 1;
        end
    end

    // Watchdog: end the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d pixels outstanding",
                         quiet_cycles, expected_pixels.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        fstm_pkg::item_t t;

        // Directed part, window at the origin
        queue_window(9'd0, 8'd0);
        t = random_item();
        t.op = fstm_pkg::OP_LOAD_TEXEL;
        t.load_addr = 14'd0;
        t.load_data = 8'h00;
        queue_item(t, 1'b0);
        t.load_addr = 14'd4095;
        t.load_data = 8'hFF;
        queue_item(t, 1'b0);
        // texel writes just above and far above the store: both dropped
        t.load_addr = 14'd4096;
        t.load_data = 8'hA5;
        queue_item(t, 1'b0);
        t.load_addr = 14'h3FFF;
        t.load_data = 8'h5A;
        queue_item(t, 1'b0);
        t.op = fstm_pkg::OP_LOAD_CMAP;
        t.load_addr = 14'd0;
        t.load_data = 8'hFF;
        queue_item(t, 1'b0);
        t.load_addr = 14'h3FFF;
        t.load_data = 8'h00;
        queue_item(t, 1'b0);
        t = random_item();
        t.op = OP_UNUSED;
        queue_item(t, 1'b0);

        // single pixel in the top-left corner, light 0, still coordinates
        t = random_item();
        t.start_x = 9'd0;
        t.row = 8'd0;
        t.run_length = 6'd0;
        t.light_level = 6'd0;
        t.u_start = 32'h0;
        t.v_start = 32'h0;
        t.u_step = 32'h0;
        t.v_step = 32'h0;
        queue_span(t, 1'b0);

        // longest span from the right edge: all but the first pixel off screen,
        // u crosses the positive limit and v wraps below the negative one
        t = random_item();
        t.start_x = 9'd319;
        t.row = 8'd199;
        t.run_length = 6'd63;
        t.light_level = 6'd63;
        t.u_start = 32'h7FE0_0000;
        t.u_step = 32'h0100_0000;
        t.v_start = 32'h8000_0000;
        t.v_step = 32'hFFFF_0000;
        queue_span(t, 1'b0);

        // extreme steps and start values
        t = random_item();
        t.u_start = 32'hFFFF_FFFF;
        t.v_start = 32'h7FFF_FFFF;
        t.u_step = 32'h7FFF_FFFF;
        t.v_step = 32'h8000_0000;
        queue_span(t, 1'b0);
        queue_drain();

        // Window pushed to its far corner
        queue_window(9'd319, 8'd199);
        t = random_item();
        t.start_x = 9'd0;
        t.row = 8'd0;
        t.run_length = 6'd5;
        queue_span(t, 1'b0);
        // one row further down lands below the screen
        t = random_item();
        t.start_x = 9'd0;
        t.row = 8'd1;
        queue_span(t, 1'b0);
        t = random_item();
        t.start_x = 9'd319;
        t.row = 8'd199;
        t.run_length = 6'd63;
        queue_span(t, 1'b0);

        // Random phases across several window settings; the last runs flat out
        queue_window(9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
        random_phase(1'b0);
        queue_window(9'd319, 8'd0);
        random_phase(1'b0);
        queue_window(9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
        random_phase(1'b0);
        queue_window(9'd0, 8'd199);
        random_phase(1'b0);
        queue_window(9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
        random_phase(1'b1);

        // Reset once, then let the driver run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transaction, then for the last pixel, then linger
        @(posedge clk);
        while (pending_jobs.size() != 0 || start)
            @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            errors++;
        end

        $display("summary: %0d transactions sent, %0d spans drawn, %0d pixels checked",
                 sent_count, spans_seen, pixels_checked);
        $display("summary: %0d window settings, %0d mismatches", window_count, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/fstm_pkg.sv
hdl/fstm_front.sv
hdl/fstm_queue.sv
hdl/fstm_back.sv
hdl/flat_span_texture_mapper.sv
dv/tb_top.sv
